/* hdl/mcuc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mcuc_pkg
// Shared types and constants of the mip chain upload checker.
// ----------------------------------------------------------------------------
package mcuc_pkg;

  // Largest base extent accepted, in texels.
  localparam logic [16:0] MAX_DIMENSION = 17'd16384;
  // Longest descriptor, in levels.
  localparam logic [4:0]  MAX_LEVELS    = 5'd15;

  localparam logic [2:0] FMT_RGBA8 = 3'd1;
  localparam logic [2:0] FMT_BC1   = 3'd2;
  localparam logic [2:0] FMT_LAST  = 3'd5;

  localparam logic [2:0] WRAP_FIRST = 3'd1;
  localparam logic [2:0] WRAP_LAST  = 3'd4;

  localparam logic [1:0] FILT_INVALID = 2'd0;
  localparam logic [1:0] FILT_ANISO   = 2'd3;
  localparam logic [1:0] MIP_NONE     = 2'd0;
  localparam logic [1:0] MIP_INVALID  = 2'd3;
  localparam logic [1:0] CS_LAST      = 2'd1;

  typedef enum logic [3:0] {
    VRD_OK        = 4'd0,
    VRD_FORMAT    = 4'd1,
    VRD_COLOR     = 4'd2,
    VRD_WRAP      = 4'd3,
    VRD_FILTER    = 4'd4,
    VRD_ANISO     = 4'd5,
    VRD_COUNT     = 4'd6,
    VRD_MIPFILTER = 4'd7,
    VRD_BASE_DIMS = 4'd8,
    VRD_PARTIAL   = 4'd9,
    VRD_EXTENT    = 4'd10,
    VRD_OVERFLOW  = 4'd11,
    VRD_BYTES     = 4'd12
  } verdict_t;

  typedef enum logic [2:0] {
    REG_TEX_FORMAT  = 3'd0,
    REG_COLOR_SPACE = 3'd1,
    REG_WRAP_U      = 3'd2,
    REG_WRAP_V      = 3'd3,
    REG_MIN_FILTER  = 3'd4,
    REG_MAG_FILTER  = 3'd5,
    REG_MIP_FILTER  = 3'd6,
    REG_LEVELS      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0] tex_format;
    logic [1:0] color_space;
    logic [2:0] wrap_u_mode;
    logic [2:0] wrap_v_mode;
    logic [1:0] min_filter_mode;
    logic [1:0] mag_filter_mode;
    logic [1:0] mip_filter_mode;
    logic [4:0] levels_in_upload;
  } cfg_t;

  // Per-descriptor state carried from one level to the next.
  typedef struct packed {
    logic [15:0] expected_width;
    logic [15:0] expected_height;
    verdict_t    held_verdict;
  } lvl_state_t;

endpackage : mcuc_pkg
`default_nettype wire

/* hdl/mcuc_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mcuc_cfg_regs
// APB register file holding the texture header and the level count.
// ----------------------------------------------------------------------------
module mcuc_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mcuc_pkg::cfg_t     cfg
);

  mcuc_pkg::cfg_t     cfg_r;
  mcuc_pkg::cfg_t     cfg_nxt;
  mcuc_pkg::reg_idx_t sel;
  logic               wr_en;

  assign pready = 1'b1;
  assign sel    = mcuc_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (sel)
        mcuc_pkg::REG_TEX_FORMAT:  cfg_nxt.tex_format       = pwdata[2:0];
        mcuc_pkg::REG_COLOR_SPACE: cfg_nxt.color_space      = pwdata[1:0];
        mcuc_pkg::REG_WRAP_U:      cfg_nxt.wrap_u_mode      = pwdata[2:0];
        mcuc_pkg::REG_WRAP_V:      cfg_nxt.wrap_v_mode      = pwdata[2:0];
        mcuc_pkg::REG_MIN_FILTER:  cfg_nxt.min_filter_mode  = pwdata[1:0];
        mcuc_pkg::REG_MAG_FILTER:  cfg_nxt.mag_filter_mode  = pwdata[1:0];
        mcuc_pkg::REG_MIP_FILTER:  cfg_nxt.mip_filter_mode  = pwdata[1:0];
        mcuc_pkg::REG_LEVELS:      cfg_nxt.levels_in_upload = pwdata[4:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      mcuc_pkg::REG_TEX_FORMAT:  prdata = {29'd0, cfg_r.tex_format};
      mcuc_pkg::REG_COLOR_SPACE: prdata = {30'd0, cfg_r.color_space};
      mcuc_pkg::REG_WRAP_U:      prdata = {29'd0, cfg_r.wrap_u_mode};
      mcuc_pkg::REG_WRAP_V:      prdata = {29'd0, cfg_r.wrap_v_mode};
      mcuc_pkg::REG_MIN_FILTER:  prdata = {30'd0, cfg_r.min_filter_mode};
      mcuc_pkg::REG_MAG_FILTER:  prdata = {30'd0, cfg_r.mag_filter_mode};
      mcuc_pkg::REG_MIP_FILTER:  prdata = {30'd0, cfg_r.mip_filter_mode};
      mcuc_pkg::REG_LEVELS:      prdata = {27'd0, cfg_r.levels_in_upload};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tex_format       <= 3'd0;
      cfg_r.color_space      <= 2'd0;
      cfg_r.wrap_u_mode      <= 3'd1;
      cfg_r.wrap_v_mode      <= 3'd1;
      cfg_r.min_filter_mode  <= 2'd1;
      cfg_r.mag_filter_mode  <= 2'd1;
      cfg_r.mip_filter_mode  <= 2'd0;
      cfg_r.levels_in_upload <= 5'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule : mcuc_cfg_regs
`default_nettype wire

/* hdl/mcuc_level_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mcuc_level_check
// Header, extent and byte size checks for one mip level.
// ----------------------------------------------------------------------------
module mcuc_level_check (
  input  wire mcuc_pkg::cfg_t       cfg,
  input  wire logic                 first,
  input  wire logic [15:0]          level_width,
  input  wire logic [15:0]          level_height,
  input  wire logic [31:0]          byte_count,
  input  wire mcuc_pkg::lvl_state_t st,
  output mcuc_pkg::lvl_state_t      st_nxt
);

  mcuc_pkg::verdict_t hdr_verdict;
  mcuc_pkg::verdict_t base_verdict;
  logic [15:0]        exp_w;
  logic [15:0]        exp_h;
  logic [3:0]         msb_w;
  logic [3:0]         msb_h;
  logic [4:0]         chain_len;
  logic [4:0]         n;
  logic [16:0]        blk_w;
  logic [16:0]        blk_h;
  logic [15:0]        mul_a;
  logic [15:0]        mul_b;
  logic [31:0]        prod;
  logic [35:0]        size;
  logic               hdr_fmt_bad;
  logic               hdr_wrap_bad;

  // Index of the leading one; zero and one both give zero halvings.
  always_comb begin
    msb_w = 4'd0;
    msb_h = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (level_width[i])  msb_w = 4'(i);
      if (level_height[i]) msb_h = 4'(i);
    end
    chain_len = (msb_w > msb_h) ? (5'd1 + {1'b0, msb_w}) : (5'd1 + {1'b0, msb_h});
  end

  assign n            = cfg.levels_in_upload;
  assign hdr_fmt_bad  = (cfg.tex_format < mcuc_pkg::FMT_RGBA8) ||
                        (cfg.tex_format > mcuc_pkg::FMT_LAST);
  assign hdr_wrap_bad = (cfg.wrap_u_mode < mcuc_pkg::WRAP_FIRST) ||
                        (cfg.wrap_u_mode > mcuc_pkg::WRAP_LAST) ||
                        (cfg.wrap_v_mode < mcuc_pkg::WRAP_FIRST) ||
                        (cfg.wrap_v_mode > mcuc_pkg::WRAP_LAST);

  always_comb begin
    priority if (hdr_fmt_bad) begin
      hdr_verdict = mcuc_pkg::VRD_FORMAT;
    end else if (cfg.color_space > mcuc_pkg::CS_LAST) begin
      hdr_verdict = mcuc_pkg::VRD_COLOR;
    end else if (hdr_wrap_bad) begin
      hdr_verdict = mcuc_pkg::VRD_WRAP;
    end else if ((cfg.min_filter_mode == mcuc_pkg::FILT_INVALID) ||
                 (cfg.mag_filter_mode == mcuc_pkg::FILT_INVALID) ||
                 (cfg.mip_filter_mode == mcuc_pkg::MIP_INVALID)) begin
      hdr_verdict = mcuc_pkg::VRD_FILTER;
    end else if ((cfg.min_filter_mode == mcuc_pkg::FILT_ANISO) !=
                 (cfg.mag_filter_mode == mcuc_pkg::FILT_ANISO)) begin
      hdr_verdict = mcuc_pkg::VRD_ANISO;
    end else if ((n == 5'd0) || (n > mcuc_pkg::MAX_LEVELS)) begin
      hdr_verdict = mcuc_pkg::VRD_COUNT;
    end else if (((n == 5'd1) && (cfg.mip_filter_mode != mcuc_pkg::MIP_NONE)) ||
                 ((n > 5'd1) && (cfg.mip_filter_mode == mcuc_pkg::MIP_NONE))) begin
      hdr_verdict = mcuc_pkg::VRD_MIPFILTER;
    end else if ((level_width == 16'd0) || (level_height == 16'd0) ||
                 ({1'b0, level_width} > mcuc_pkg::MAX_DIMENSION) ||
                 ({1'b0, level_height} > mcuc_pkg::MAX_DIMENSION)) begin
      hdr_verdict = mcuc_pkg::VRD_BASE_DIMS;
    end else if ((n > 5'd1) && (n != chain_len)) begin
      hdr_verdict = mcuc_pkg::VRD_PARTIAL;
    end else begin
      hdr_verdict = mcuc_pkg::VRD_OK;
    end
  end

  // On the first level the expected extent is the level's own extent.
  assign exp_w        = first ? level_width  : st.expected_width;
  assign exp_h        = first ? level_height : st.expected_height;
  assign base_verdict = first ? hdr_verdict  : st.held_verdict;

  // Compressed formats are counted in 4x4 blocks, rounded up.
  assign blk_w = ({1'b0, level_width}  + 17'd3) >> 2;
  assign blk_h = ({1'b0, level_height} + 17'd3) >> 2;
  assign mul_a = (cfg.tex_format == mcuc_pkg::FMT_RGBA8) ? level_width  : blk_w[15:0];
  assign mul_b = (cfg.tex_format == mcuc_pkg::FMT_RGBA8) ? level_height : blk_h[15:0];
  assign prod  = mul_a * mul_b;

  always_comb begin
    unique case (cfg.tex_format)
      mcuc_pkg::FMT_RGBA8: size = {prod, 4'd0} >> 2;
      mcuc_pkg::FMT_BC1:   size = {prod, 4'd0} >> 1;
      default:             size = {prod, 4'd0};
    endcase
  end

  always_comb begin
    st_nxt.held_verdict = base_verdict;
    if (base_verdict == mcuc_pkg::VRD_OK) begin
      priority if ((level_width != exp_w) || (level_height != exp_h)) begin
        st_nxt.held_verdict = mcuc_pkg::VRD_EXTENT;
      end else if (size[35:32] != 4'd0) begin
        st_nxt.held_verdict = mcuc_pkg::VRD_OVERFLOW;
      end else if (byte_count != size[31:0]) begin
        st_nxt.held_verdict = mcuc_pkg::VRD_BYTES;
      end else begin
        st_nxt.held_verdict = mcuc_pkg::VRD_OK;
      end
    end
    st_nxt.expected_width  = (exp_w > 16'd1) ? (exp_w >> 1) : 16'd1;
    st_nxt.expected_height = (exp_h > 16'd1) ? (exp_h >> 1) : 16'd1;
  end

endmodule : mcuc_level_check
`default_nettype wire

/* hdl/mip_chain_upload_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mip_chain_upload_checker
// Checks a 2D texture upload one mip level word at a time.
// ----------------------------------------------------------------------------
// The texture header and the number of levels per descriptor are written over
// the APB port; the user writes them only while no level is in flight, which
// the block does not enforce. Each input word carries one level's width,
// height and byte count; each output word carries the verdict so far, the
// level's index within the descriptor and, on tlast, the mark that the verdict
// is final. The first error of a descriptor is held until its last level.
// A word taken on the input is registered, checked combinationally and, once
// the output register is free or being emptied, lands in the output register,
// which drives out_tvalid. One word is taken every cycle while the receiver
// does not stall; the rate is set by the single check stage between the input
// and output registers.
// The input register accepts a new word while a finished result waits at the
// output; once both hold a word and the receiver stalls, in_tready falls.
// Reset returns the registers to their defaults, empties both stages and
// starts a new descriptor at level zero.
// ----------------------------------------------------------------------------
module mip_chain_upload_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // [15:0] level_width, [31:16] level_height, [63:32] byte_count
  input  wire logic [63:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [3:0] verdict, [8:4] level_number, [15:9] zero
  output logic [15:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  mcuc_pkg::cfg_t       cfg;
  mcuc_pkg::lvl_state_t st_r;
  mcuc_pkg::lvl_state_t st_nxt;

  logic        s1_v_r;
  logic [15:0] s1_w_r;
  logic [15:0] s1_h_r;
  logic [31:0] s1_bytes_r;
  logic [4:0]  level_cnt_r;
  logic        out_v_r;
  logic [3:0]  out_verdict_r;
  logic [4:0]  out_level_r;
  logic        out_done_r;

  logic        adv;
  logic        take;
  logic [5:0]  desc_len;
  logic        done;

  mcuc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mcuc_level_check u_chk (
    .cfg          (cfg),
    .first        (level_cnt_r == 5'd0),
    .level_width  (s1_w_r),
    .level_height (s1_h_r),
    .byte_count   (s1_bytes_r),
    .st           (st_r),
    .st_nxt       (st_nxt)
  );

  // A zero level count still closes the descriptor after one word.
  assign desc_len = (cfg.levels_in_upload == 5'd0) ? 6'd1 : {1'b0, cfg.levels_in_upload};
  assign done     = ({1'b0, level_cnt_r} + 6'd1) >= desc_len;

  assign adv       = s1_v_r & (~out_v_r | out_tready);
  assign in_tready = ~s1_v_r | adv;
  assign take      = in_tvalid & in_tready;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_level_r, out_verdict_r};
  assign out_tlast  = out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      level_cnt_r  <= 5'd0;
      st_r.expected_width  <= 16'd0;
      st_r.expected_height <= 16'd0;
      st_r.held_verdict    <= mcuc_pkg::VRD_OK;
    end else begin
      if (take) begin
        s1_v_r     <= 1'b1;
        s1_w_r     <= in_tdata[15:0];
        s1_h_r     <= in_tdata[31:16];
        s1_bytes_r <= in_tdata[63:32];
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r       <= 1'b1;
        out_verdict_r <= st_nxt.held_verdict;
        out_level_r   <= level_cnt_r;
        out_done_r    <= done;
        st_r          <= st_nxt;
        level_cnt_r   <= done ? 5'd0 : (level_cnt_r + 5'd1);
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

endmodule : mip_chain_upload_checker
`default_nettype wire

/* sim/mip_chain_upload_checker_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mip_chain_upload_checker_test
// Self-checking bench for the mip chain upload checker.
// ----------------------------------------------------------------------------
// The header registers are loaded over APB while the block is idle. Level
// words are then streamed in with random gaps and random output stalls. A
// behavioural copy of the checker predicts the verdict, level index and
// last-level mark of every word, and each output word is compared with the
// oldest prediction. A short directed part covers the field extremes and
// every header error. The random part that follows is mostly well-formed
// descriptors, with some damaged levels, bad bases, noise words and
// descriptors cut short before the level count changes.
// ----------------------------------------------------------------------------
module mip_chain_upload_checker_test;
  import mcuc_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 300000;

  // Codes the package does not name.
  localparam logic [2:0] FMT_INVALID = 3'd0;
  localparam logic [2:0] FMT_BAD     = 3'd7;
  localparam logic [1:0] CS_LINEAR   = 2'd0;
  localparam logic [1:0] CS_SRGB     = 2'd1;
  localparam logic [1:0] CS_BAD      = 2'd2;
  localparam logic [2:0] WRAP_NONE   = 3'd0;
  localparam logic [1:0] FILT_POINT  = 2'd1;
  localparam logic [1:0] FILT_LINEAR = 2'd2;
  localparam logic [1:0] MIP_POINT   = 2'd1;
  localparam logic [1:0] MIP_LINEAR  = 2'd2;

  typedef struct packed {
    verdict_t   verdict;
    logic [4:0] level;
    logic       last;
  } level_report_t;

  logic        clk;
  logic        rst_n;
  // [15:0] level_width, [31:16] level_height, [63:32] byte_count
  logic [63:0] in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  // [3:0] verdict, [8:4] level_number, [15:9] zero
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mip_chain_upload_checker i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Header copy and per-descriptor state of the predictor.
  cfg_t        shadow;
  logic [4:0]  level_idx;
  logic [15:0] want_w;
  logic [15:0] want_h;
  verdict_t    held;

  logic [63:0]   pending_levels[$];
  level_report_t expected_verdicts[$];
  level_report_t oldest;

  logic        in_busy;
  logic        word_taken;
  int          in_hold;
  int          out_hold;
  int          in_odds;
  int          out_odds;
  int          cycle_count;
  int          mismatch_count;
  int          words_queued;
  int          words_taken;
  int          descriptors_closed;
  int          clean_descriptors;
  int          setups_loaded;
  logic [15:0] verdicts_hit;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] next_extent(logic [15:0] e);
    return (e > 16'd1) ? (e >> 1) : 16'd1;
  endfunction

  function automatic int full_chain_length(logic [15:0] w, logic [15:0] h);
    int n;
    n = 1;
    for (int i = 0; i < 20; i++) begin
      if (w <= 16'd1 && h <= 16'd1) break;
      w = next_extent(w);
      h = next_extent(h);
      n++;
    end
    return n;
  endfunction

  function automatic verdict_t header_check(logic [15:0] w, logic [15:0] h);
    int n;
    n = int'(shadow.levels_in_upload);
    if (shadow.tex_format < FMT_RGBA8 || shadow.tex_format > FMT_LAST) return VRD_FORMAT;
    if (shadow.color_space > CS_LAST) return VRD_COLOR;
    if (shadow.wrap_u_mode < WRAP_FIRST || shadow.wrap_u_mode > WRAP_LAST ||
        shadow.wrap_v_mode < WRAP_FIRST || shadow.wrap_v_mode > WRAP_LAST) return VRD_WRAP;
    if (shadow.min_filter_mode == FILT_INVALID || shadow.mag_filter_mode == FILT_INVALID ||
        shadow.mip_filter_mode == MIP_INVALID) return VRD_FILTER;
    if ((shadow.min_filter_mode == FILT_ANISO) != (shadow.mag_filter_mode == FILT_ANISO))
      return VRD_ANISO;
    if (n == 0 || n > int'(MAX_LEVELS)) return VRD_COUNT;
    if ((n == 1 && shadow.mip_filter_mode != MIP_NONE) ||
        (n > 1 && shadow.mip_filter_mode == MIP_NONE)) return VRD_MIPFILTER;
    if (w == 16'd0 || h == 16'd0 || w > MAX_DIMENSION || h > MAX_DIMENSION)
      return VRD_BASE_DIMS;
    if (n > 1 && n != full_chain_length(w, h)) return VRD_PARTIAL;
    return VRD_OK;
  endfunction

  // RGBA8 is 4 bytes a texel; block formats round up to 4x4 blocks of 8 or 16 bytes.
  function automatic logic [63:0] level_bytes(logic [15:0] w, logic [15:0] h);
    logic [63:0] bx;
    logic [63:0] by;
    if (shadow.tex_format == FMT_RGBA8) return 64'(w) * 64'(h) * 64'd4;
    bx = (64'(w) + 64'd3) / 64'd4;
    by = (64'(h) + 64'd3) / 64'd4;
    return bx * by * ((shadow.tex_format == FMT_BC1) ? 64'd8 : 64'd16);
  endfunction

  function automatic void judge_level(logic [63:0] word);
    logic [15:0]   w;
    logic [15:0]   h;
    logic [31:0]   bytes;
    logic [63:0]   size;
    int            span;
    level_report_t rep;
    w     = word[15:0];
    h     = word[31:16];
    bytes = word[63:32];
    // A zero level count still closes the descriptor after one word.
    span      = (shadow.levels_in_upload == 5'd0) ? 1 : int'(shadow.levels_in_upload);
    rep.level = level_idx;
    rep.last  = (int'(level_idx) + 1) >= span;
    if (level_idx == 5'd0) begin
      held   = header_check(w, h);
      want_w = w;
      want_h = h;
    end
    if (held == VRD_OK) begin
      size = level_bytes(w, h);
      if (w != want_w || h != want_h) held = VRD_EXTENT;
      else if (size > 64'hFFFF_FFFF) held = VRD_OVERFLOW;
      else if (bytes != size[31:0]) held = VRD_BYTES;
    end
    want_w      = next_extent(want_w);
    want_h      = next_extent(want_h);
    rep.verdict = held;
    expected_verdicts.push_back(rep);
    level_idx = rep.last ? 5'd0 : level_idx + 5'd1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic push_level(logic [15:0] w, logic [15:0] h, logic [31:0] bytes);
    pending_levels.push_back({bytes, h, w});
    words_queued++;
  endtask

  // Queues a halving chain with exact sizes; one level may be damaged on purpose.
  task automatic queue_chain(logic [15:0] bw, logic [15:0] bh, int count, int flaw);
    logic [63:0] sz;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] fw;
    logic [15:0] fh;
    logic [31:0] fb;
    int          k;
    w = bw;
    h = bh;
    for (int i = 0; i < count; i++) begin
      sz = level_bytes(w, h);
      fw = w;
      fh = h;
      fb = sz[31:0];
      if (i == flaw) begin
        case ($urandom_range(0, 2))
          0: begin
            k = $urandom_range(0, 15);
            fw[k] = ~fw[k];
          end
          1: begin
            k = $urandom_range(0, 15);
            fh[k] = ~fh[k];
          end
          default: begin
            k = $urandom_range(0, 31);
            fb[k] = ~fb[k];
          end
        endcase
      end
      push_level(fw, fh, fb);
      w = next_extent(w);
      h = next_extent(h);
    end
  endtask

  task automatic queue_upload(int span, int levels);
    int          lo;
    int          hi;
    int          m;
    int          kind;
    int          flaw;
    logic [15:0] bw;
    logic [15:0] bh;
    logic [15:0] tmp;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat (span) push_level(16'($urandom), 16'($urandom), $urandom);
    end else begin
      // Pick the larger extent so that the chain is exactly as long as the count.
      if (levels >= 2 && levels <= int'(MAX_LEVELS)) begin
        lo = 1 << (levels - 1);
        hi = (1 << levels) - 1;
        if (hi > int'(MAX_DIMENSION)) hi = int'(MAX_DIMENSION);
      end else begin
        lo = 1;
        hi = ($urandom_range(0, 7) == 0) ? int'(MAX_DIMENSION) : 64;
      end
      m = $urandom_range(lo, hi);
      if (kind == 1) m = $urandom_range(0, 1) ? 0 : $urandom_range(16385, 65535);
      else if (kind == 2) m = $urandom_range(1, int'(MAX_DIMENSION));
      bw = 16'(m);
      bh = 16'($urandom_range(1, (m == 0) ? int'(MAX_DIMENSION) : m));
      if ($urandom_range(0, 1)) begin
        tmp = bw;
        bw  = bh;
        bh  = tmp;
      end
      flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1) : -1;
      queue_chain(bw, bh, span, flaw);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_TEX_FORMAT:  shadow.tex_format      = value[2:0];
      REG_COLOR_SPACE: shadow.color_space     = value[1:0];
      REG_WRAP_U:      shadow.wrap_u_mode     = value[2:0];
      REG_WRAP_V:      shadow.wrap_v_mode     = value[2:0];
      REG_MIN_FILTER:  shadow.min_filter_mode = value[1:0];
      REG_MAG_FILTER:  shadow.mag_filter_mode = value[1:0];
      REG_MIP_FILTER:  shadow.mip_filter_mode = value[1:0];
      default:         shadow.levels_in_upload = value[4:0];
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setup(cfg_t c);
    write_reg(REG_TEX_FORMAT, 32'(c.tex_format));
    write_reg(REG_COLOR_SPACE, 32'(c.color_space));
    write_reg(REG_WRAP_U, 32'(c.wrap_u_mode));
    write_reg(REG_WRAP_V, 32'(c.wrap_v_mode));
    write_reg(REG_MIN_FILTER, 32'(c.min_filter_mode));
    write_reg(REG_MAG_FILTER, 32'(c.mag_filter_mode));
    write_reg(REG_MIP_FILTER, 32'(c.mip_filter_mode));
    write_reg(REG_LEVELS, 32'(c.levels_in_upload));
    setups_loaded++;
  endtask

  // Waits until every queued word has been sent and answered.
  task automatic settle();
    while (pending_levels.size() != 0 || in_busy || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Input driver: holds a word until it is taken, with bursts of gaps in between.
  always @(negedge clk) begin
    if (word_taken) begin
      word_taken = 1'b0;
      in_busy    = 1'b0;
    end
    if (!in_busy) begin
      if (in_hold != 0) begin
        in_hold--;
      end else if (pending_levels.size() != 0) begin
        if (in_odds != 0 && $urandom_range(1, in_odds) == 1) begin
          in_hold = $urandom_range(0, 3);
        end else begin
          in_tdata <= pending_levels.pop_front();
          in_busy = 1'b1;
        end
      end
    end
    in_tvalid <= in_busy;
  end

  always @(negedge clk) begin
    if (out_hold != 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else if (out_odds != 0 && $urandom_range(1, out_odds) == 1) begin
      out_hold = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d words outstanding",
                 cycle_count, expected_verdicts.size());
        $display("[FAIL] regression broken");
        $finish;
      end
      if (in_tvalid && in_tready) begin
        judge_level(in_tdata);
        word_taken = 1'b1;
        words_taken++;
      end
      if (out_tvalid && out_tready) begin
        verdicts_hit[out_tdata[3:0]] = 1'b1;
        if (out_tlast) begin
          descriptors_closed++;
          if (out_tdata[3:0] == VRD_OK) clean_descriptors++;
        end
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result word with nothing outstanding", int'(out_tdata), 0);
        end else begin
          oldest = expected_verdicts.pop_front();
          if (out_tdata[3:0] != oldest.verdict)
            report_mismatch("verdict", int'(out_tdata[3:0]), int'(oldest.verdict));
          if (out_tdata[8:4] != oldest.level)
            report_mismatch("level number", int'(out_tdata[8:4]), int'(oldest.level));
          if (out_tlast != oldest.last)
            report_mismatch("last level mark", int'(out_tlast), int'(oldest.last));
        end
      end
    end
  end

  initial begin
    cfg_t setup;
    int   span;
    int   first_random;

    rst_n        = 1'b0;
    in_tdata     = '0;
    in_tvalid    = 1'b0;
    out_tready   = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_busy      = 1'b0;
    word_taken   = 1'b0;
    in_hold      = 0;
    out_hold     = 0;
    in_odds      = 4;
    out_odds     = 4;
    verdicts_hit = '0;
    level_idx    = '0;
    want_w       = '0;
    want_h       = '0;
    held         = VRD_OK;
    shadow       = '{tex_format: FMT_INVALID, color_space: CS_LINEAR,
                     wrap_u_mode: WRAP_FIRST, wrap_v_mode: WRAP_FIRST,
                     min_filter_mode: FILT_POINT, mag_filter_mode: FILT_POINT,
                     mip_filter_mode: MIP_NONE, levels_in_upload: 5'd1};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The reset header has no valid format.
    push_level(16'd1, 16'd1, 32'd4);
    settle();

    setup = '{tex_format: FMT_RGBA8, color_space: CS_SRGB,
              wrap_u_mode: WRAP_LAST, wrap_v_mode: WRAP_FIRST,
              min_filter_mode: FILT_POINT, mag_filter_mode: FILT_LINEAR,
              mip_filter_mode: MIP_NONE, levels_in_upload: 5'd1};
    load_setup(setup);
    push_level(16'd1, 16'd1, 32'd4);
    push_level(16'd16384, 16'd16384, 32'h4000_0000);
    push_level(16'd0, 16'd7, 32'd0);
    push_level(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    settle();

    // Three-level BC1 chains: clean, bad extent, bad size and too short a chain.
    write_reg(REG_TEX_FORMAT, 32'(FMT_BC1));
    write_reg(REG_MIP_FILTER, 32'(MIP_LINEAR));
    write_reg(REG_LEVELS, 32'd3);
    queue_chain(16'd4, 16'd3, 3, -1);
    push_level(16'd5, 16'd4, 32'd16);
    push_level(16'd3, 16'd2, 32'd8);
    push_level(16'd1, 16'd1, 32'd8);
    push_level(16'd4, 16'd4, 32'd8);
    push_level(16'd2, 16'd2, 32'd8);
    push_level(16'd1, 16'd1, 32'd9);
    queue_chain(16'd8, 16'd8, 3, -1);
    settle();

    // One header error at a time, single-level descriptors.
    write_reg(REG_LEVELS, 32'd1);
    write_reg(REG_MIP_FILTER, 32'(MIP_NONE));
    write_reg(REG_TEX_FORMAT, 32'(FMT_BAD));
    push_level(16'd1, 16'd1, 32'd16);
    settle();
    write_reg(REG_TEX_FORMAT, 32'(FMT_LAST));
    write_reg(REG_COLOR_SPACE, 32'(CS_BAD));
    push_level(16'd1, 16'd1, 32'd16);
    settle();
    write_reg(REG_COLOR_SPACE, 32'(CS_LINEAR));
    write_reg(REG_WRAP_V, 32'(WRAP_NONE));
    push_level(16'd1, 16'd1, 32'd16);
    settle();
    write_reg(REG_WRAP_V, 32'(WRAP_LAST));
    write_reg(REG_MIN_FILTER, 32'(FILT_INVALID));
    push_level(16'd1, 16'd1, 32'd16);
    settle();
    write_reg(REG_MIN_FILTER, 32'(FILT_ANISO));
    push_level(16'd1, 16'd1, 32'd16);
    settle();
    write_reg(REG_MAG_FILTER, 32'(FILT_ANISO));
    write_reg(REG_MIP_FILTER, 32'(MIP_INVALID));
    push_level(16'd1, 16'd1, 32'd16);
    settle();
    write_reg(REG_MIP_FILTER, 32'(MIP_NONE));
    write_reg(REG_LEVELS, 32'd0);
    push_level(16'd1, 16'd1, 32'd16);
    settle();
    write_reg(REG_LEVELS, 32'd1);
    write_reg(REG_MIP_FILTER, 32'(MIP_POINT));
    push_level(16'd1, 16'd1, 32'd16);
    settle();

    first_random = words_queued;
    while (words_queued - first_random < RANDOM_ITEMS) begin
      setup.levels_in_upload = 5'($urandom_range(1, int'(MAX_LEVELS)));
      setup.tex_format       = 3'($urandom_range(FMT_RGBA8, FMT_LAST));
      setup.color_space      = 2'($urandom_range(CS_LINEAR, CS_LAST));
      setup.wrap_u_mode      = 3'($urandom_range(WRAP_FIRST, WRAP_LAST));
      setup.wrap_v_mode      = 3'($urandom_range(WRAP_FIRST, WRAP_LAST));
      if ($urandom_range(0, 3) == 0) begin
        setup.min_filter_mode = FILT_ANISO;
        setup.mag_filter_mode = FILT_ANISO;
      end else begin
        setup.min_filter_mode = 2'($urandom_range(FILT_POINT, FILT_LINEAR));
        setup.mag_filter_mode = 2'($urandom_range(FILT_POINT, FILT_LINEAR));
      end
      setup.mip_filter_mode = (setup.levels_in_upload == 5'd1) ? MIP_NONE :
                              2'($urandom_range(MIP_POINT, MIP_LINEAR));
      // Now and then one register takes any value that its width allows.
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 7))
          0:       setup.tex_format       = 3'($urandom);
          1:       setup.color_space      = 2'($urandom);
          2:       setup.wrap_u_mode      = 3'($urandom);
          3:       setup.wrap_v_mode      = 3'($urandom);
          4:       setup.min_filter_mode  = 2'($urandom);
          5:       setup.mag_filter_mode  = 2'($urandom);
          6:       setup.mip_filter_mode  = 2'($urandom);
          default: setup.levels_in_upload = 5'($urandom);
        endcase
      end
      load_setup(setup);

      if (words_queued - first_random >= RANDOM_ITEMS * 7 / 8) begin
        in_odds  = 0;
        out_odds = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       in_odds = 0;
          1:       in_odds = 3;
          default: in_odds = 8;
        endcase
        case ($urandom_range(0, 2))
          0:       out_odds = 0;
          1:       out_odds = 3;
          default: out_odds = 8;
        endcase
      end

      span = (setup.levels_in_upload == 5'd0) ? 1 : int'(setup.levels_in_upload);
      repeat ($urandom_range(1, 4)) queue_upload(span, int'(setup.levels_in_upload));
      // A descriptor left unfinished here runs on under the next level count.
      if (span > 1 && $urandom_range(0, 5) == 0)
        queue_chain(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)),
                    $urandom_range(1, span - 1), -1);
      settle();
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Checked %0d level words under %0d header settings; %0d descriptors closed, %0d clean.",
             words_taken, setups_loaded, descriptors_closed, clean_descriptors);
    $display("Distinct verdict codes seen: %0d; mismatches: %0d.",
             $countones(verdicts_hit), mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* mip_chain_upload_checker.f */
hdl/mcuc_pkg.sv
hdl/mcuc_cfg_regs.sv
hdl/mcuc_level_check.sv
hdl/mip_chain_upload_checker.sv
sim/mip_chain_upload_checker_test.sv
